@@ sv/pcs_pkg.sv @@
// Package of the pump cycle supervisor: constants, register indexes, codes,
// the per-tick record passed from the front to the back, and the back's states.
// No dependencies.
package pcs_pkg;

  localparam int TimeWidth = 32;
  localparam int CmpWidth  = (TimeWidth > 32) ? TimeWidth : 32;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int InDataW  = 8;
  localparam int OutDataW = 8;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Register values after reset.
  localparam logic [15:0] MinOnReset    = 16'd10000;
  localparam logic [31:0] MaxIdleReset  = 32'd43200000;
  localparam logic [7:0]  AlarmLimReset = 8'd2;
  localparam logic [15:0] PeriodReset   = 16'd2000;
  localparam logic [9:0]  HoldoffReset  = 10'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinOn        = 3'd0,
    CfgMaxIdle      = 3'd1,
    CfgAlarmLimit   = 3'd2,
    CfgReportPeriod = 3'd3,
    CfgHoldoff      = 3'd4
  } cfg_idx_e;

  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusLowAir     = 2'd1;
  localparam logic [1:0] StatusNoActivity = 2'd2;

  localparam logic [1:0] ToggleNone = 2'd0;
  localparam logic [1:0] ToggleOn   = 2'd1;
  localparam logic [1:0] ToggleOff  = 2'd2;

  localparam logic KindToggle = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Everything the back needs to emit the reports of one tick.
  typedef struct packed {
    logic       tog_v;
    logic [1:0] tog_code;
    logic       rep_v;
    logic [1:0] status;
    logic       pump_on;
  } tick_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkToggle,
    BkStatus,
    BkRepToggle
  } back_state_e;

endpackage

@@ sv/pump_cycle_supervisor.sv @@
// Top level of the pump cycle supervisor: front, record queue and back.
// Depends on pcs_pkg, pcs_front, pcs_queue and pcs_back.
//
// Usage: one input item per millisecond tick carries the sampled pump switch
// level in s_axis_tdata[0]. Each tick yields zero to three report items on the
// master side: a toggle report when the level changes outside the hold-off
// window, and every report_period ticks a status report followed by a toggle
// report repeating the last toggle. tlast marks the final report of a tick.
// The configuration port writes a register at every clock edge with cfg_we_i
// high; the user must write it only while the block is idle (not enforced).
// Throughput: the front takes one tick per cycle while the four-entry record
// queue has room. The back sends one report per cycle from its output
// register while the receiver is ready, so the sustained rate is set by the
// back; silent ticks push no record and so do not occupy it.
// With the queue empty, an accepted tick's record passes the queue, then the
// back's record register, before its first report reaches the output register.
// Reset puts the registers to their defaults, the pump state to off, status
// to no activity and the last toggle to none; no item is pending afterwards.
// When the receiver stalls, the output item holds, the back stops, the queue
// fills and then s_axis_tready drops; nothing is lost.
module pump_cycle_supervisor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pcs_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [pcs_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [0] pump_level, [7:1] zero
  input  logic [pcs_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] code, [2] pump_on, [7:3] zero
  output logic [pcs_pkg::OutDataW-1:0]   m_axis_tdata,
  // [0] report_kind
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);

  logic               push;
  logic               pop;
  pcs_pkg::tick_rec_t wr_rec;
  pcs_pkg::tick_rec_t head_rec;
  pcs_pkg::q_status_t q_status;
  logic [1:0]         code;
  logic               pump_on;

  pcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .pump_level_i (s_axis_tdata[0]),
    .q_status_i   (q_status),
    .push_o       (push),
    .rec_o        (wr_rec)
  );

  pcs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_rec_i (wr_rec),
    .pop_i    (pop),
    .rd_rec_o (head_rec),
    .status_o (q_status)
  );

  pcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_rec_i  (head_rec),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (m_axis_tuser),
    .code_o      (code),
    .pump_on_o   (pump_on),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {(pcs_pkg::OutDataW-3)'(0), pump_on, code};

endmodule

@@ sv/pcs_front.sv @@
// Front of the pump cycle supervisor: configuration registers and the per-tick
// state update, producing one record per tick that has reports.
// Depends on pcs_pkg.
module pcs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcs_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [pcs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          pump_level_i,
  input  pcs_pkg::q_status_t            q_status_i,
  output logic                          push_o,
  output pcs_pkg::tick_rec_t            rec_o
);

  logic [15:0] min_on_q, min_on_d;
  logic [31:0] max_idle_q, max_idle_d;
  logic [7:0]  alarm_lim_q, alarm_lim_d;
  logic [15:0] period_q, period_d;
  logic [9:0]  holdoff_ticks_q, holdoff_ticks_d;

  logic                          pump_q, pump_d;
  logic [9:0]                    holdoff_q, holdoff_d;
  logic [pcs_pkg::TimeWidth-1:0] since_q, since_d;
  logic [15:0]                   report_q, report_d;
  logic [15:0]                   alarm_q, alarm_d;
  logic [15:0]                   good_q, good_d;
  logic [1:0]                    status_q, status_d;
  logic [1:0]                    toggle_q, toggle_d;
  logic                          flag_q, flag_d;

  logic                          accept;
  logic                          since_sat;
  logic [pcs_pkg::TimeWidth-1:0] since_inc;
  logic [15:0]                   report_inc;
  logic [15:0]                   alarm_inc;
  logic [15:0]                   good_inc;
  logic                          toggle;
  logic                          on_edge;
  logic                          short_run;
  logic                          idle_hit;
  logic                          rep_fire;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    min_on_d        = min_on_q;
    max_idle_d      = max_idle_q;
    alarm_lim_d     = alarm_lim_q;
    period_d        = period_q;
    holdoff_ticks_d = holdoff_ticks_q;
    if (cfg_we_i) begin
      unique case (pcs_pkg::cfg_idx_e'(cfg_addr_i))
        pcs_pkg::CfgMinOn:        min_on_d        = cfg_wdata_i[15:0];
        pcs_pkg::CfgMaxIdle:      max_idle_d      = cfg_wdata_i[31:0];
        pcs_pkg::CfgAlarmLimit:   alarm_lim_d     = cfg_wdata_i[7:0];
        pcs_pkg::CfgReportPeriod: period_d        = cfg_wdata_i[15:0];
        pcs_pkg::CfgHoldoff:      holdoff_ticks_d = cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    since_sat  = (since_q == '1);
    since_inc  = since_sat ? since_q : since_q + 1'b1;
    report_inc = (report_q == '1) ? report_q : report_q + 16'd1;
    alarm_inc  = (alarm_q == '1) ? alarm_q : alarm_q + 16'd1;
    good_inc   = (good_q == '1) ? good_q : good_q + 16'd1;
    toggle     = (holdoff_q == '0) && (pump_level_i != pump_q);
    on_edge    = toggle && pump_level_i;
    short_run  = since_inc < pcs_pkg::TimeWidth'(min_on_q);
    // The incremented count exceeds the limit exactly when the old count
    // reaches it, unless the count is stuck at its ceiling.
    if (since_sat) begin
      idle_hit = pcs_pkg::CmpWidth'(since_q) > pcs_pkg::CmpWidth'(max_idle_q);
    end else begin
      idle_hit = pcs_pkg::CmpWidth'(since_q) >= pcs_pkg::CmpWidth'(max_idle_q);
    end
    idle_hit = idle_hit && !on_edge;
    rep_fire = report_inc >= period_q;

    pump_d    = pump_q;
    holdoff_d = holdoff_q;
    since_d   = since_q;
    report_d  = report_q;
    alarm_d   = alarm_q;
    good_d    = good_q;
    status_d  = status_q;
    toggle_d  = toggle_q;
    flag_d    = flag_q;

    if (accept) begin
      since_d  = on_edge ? '0 : since_inc;
      report_d = rep_fire ? '0 : report_inc;
      if (holdoff_q != '0) begin
        holdoff_d = holdoff_q - 10'd1;
      end else if (toggle) begin
        pump_d    = pump_level_i;
        holdoff_d = holdoff_ticks_q;
        if (pump_level_i) begin
          toggle_d = pcs_pkg::ToggleOn;
        end else begin
          toggle_d = pcs_pkg::ToggleOff;
          if (short_run) begin
            alarm_d = alarm_inc;
            if (alarm_inc >= {8'd0, alarm_lim_q}) begin
              status_d = pcs_pkg::StatusLowAir;
              good_d   = '0;
            end
          end else begin
            good_d = good_inc;
            if (good_inc > alarm_q) begin
              status_d = pcs_pkg::StatusOk;
              alarm_d  = '0;
            end
          end
        end
      end
      if (idle_hit) begin
        if (!flag_q) begin
          status_d = pcs_pkg::StatusNoActivity;
          flag_d   = 1'b1;
        end
      end else begin
        flag_d = 1'b0;
      end
    end

    push_o         = accept && (toggle || rep_fire);
    rec_o.tog_v    = toggle;
    rec_o.tog_code = toggle_d;
    rec_o.rep_v    = rep_fire;
    rec_o.status   = status_d;
    rec_o.pump_on  = pump_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_on_q        <= pcs_pkg::MinOnReset;
      max_idle_q      <= pcs_pkg::MaxIdleReset;
      alarm_lim_q     <= pcs_pkg::AlarmLimReset;
      period_q        <= pcs_pkg::PeriodReset;
      holdoff_ticks_q <= pcs_pkg::HoldoffReset;
      pump_q          <= 1'b0;
      holdoff_q       <= '0;
      since_q         <= '0;
      report_q        <= '0;
      alarm_q         <= '0;
      good_q          <= '0;
      status_q        <= pcs_pkg::StatusNoActivity;
      toggle_q        <= pcs_pkg::ToggleNone;
      flag_q          <= 1'b0;
    end else begin
      min_on_q        <= min_on_d;
      max_idle_q      <= max_idle_d;
      alarm_lim_q     <= alarm_lim_d;
      period_q        <= period_d;
      holdoff_ticks_q <= holdoff_ticks_d;
      pump_q          <= pump_d;
      holdoff_q       <= holdoff_d;
      since_q         <= since_d;
      report_q        <= report_d;
      alarm_q         <= alarm_d;
      good_q          <= good_d;
      status_q        <= status_d;
      toggle_q        <= toggle_d;
      flag_q          <= flag_d;
    end
  end

`ifndef ASSERT_OFF
  // A hold-off window never lets a toggle through.
  a_no_toggle_in_holdoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && holdoff_q != '0) |-> !toggle)
    else $error("toggle taken inside hold-off window");
  // An accepted on edge restarts the on-time count.
  a_on_edge_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && on_edge) |=> (since_q == '0 && pump_q))
    else $error("on edge did not restart on-time count");
  // Records are only pushed while the queue has room.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_status_i.full)
    else $error("record pushed into full queue");
`endif

endmodule

@@ sv/pcs_queue.sv @@
// Short queue of per-tick records between the front and the back of the
// pump cycle supervisor. Depends on pcs_pkg.
module pcs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pcs_pkg::tick_rec_t wr_rec_i,
  input  logic               pop_i,
  output pcs_pkg::tick_rec_t rd_rec_o,
  output pcs_pkg::q_status_t status_o
);

  pcs_pkg::tick_rec_t             mem_q [pcs_pkg::QDepth];
  logic [pcs_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [pcs_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [pcs_pkg::QPtrW:0]        count_q, count_d;

  always_comb begin
    status_o.full  = (count_q == (pcs_pkg::QPtrW+1)'(pcs_pkg::QDepth));
    status_o.empty = (count_q == '0);
    rd_rec_o       = mem_q[rd_ptr_q];
    wr_ptr_d       = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d       = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d        = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef ASSERT_OFF
  // Fill level stays within the queue depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (pcs_pkg::QPtrW+1)'(pcs_pkg::QDepth))
    else $error("queue fill level out of range");
  // Pointers and fill level stay consistent.
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[pcs_pkg::QPtrW-1:0])
    else $error("queue pointers disagree with fill level");
  // No pop from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty queue");
`endif

endmodule

@@ sv/pcs_back.sv @@
// Back of the pump cycle supervisor: takes per-tick records from the queue
// and sends their reports one item per cycle while the receiver is ready,
// through an output register. Depends on pcs_pkg.
module pcs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcs_pkg::tick_rec_t head_rec_i,
  input  pcs_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [1:0]         code_o,
  output logic               pump_on_o,
  output logic               last_o
);

  pcs_pkg::back_state_e state_q, state_d;
  pcs_pkg::tick_rec_t   rec_q, rec_d;
  logic                 valid_q, valid_d;
  logic                 kind_q, kind_d;
  logic [1:0]           code_q, code_d;
  logic                 pump_q, pump_d;
  logic                 last_q, last_d;
  logic                 out_free;
  logic                 load;

  always_comb begin
    out_free = !valid_q || out_ready_i;
    load     = (state_q != pcs_pkg::BkIdle) && out_free;
    state_d  = state_q;
    rec_d    = rec_q;
    kind_d   = kind_q;
    code_d   = code_q;
    pump_d   = pump_q;
    last_d   = last_q;
    pop_o    = 1'b0;

    unique case (state_q)
      pcs_pkg::BkToggle: begin
        kind_d = pcs_pkg::KindToggle;
        code_d = rec_q.tog_code;
        last_d = !rec_q.rep_v;
        if (load) begin
          state_d = rec_q.rep_v ? pcs_pkg::BkStatus : pcs_pkg::BkIdle;
        end
      end
      pcs_pkg::BkStatus: begin
        kind_d = pcs_pkg::KindStatus;
        code_d = rec_q.status;
        last_d = 1'b0;
        if (load) begin
          state_d = pcs_pkg::BkRepToggle;
        end
      end
      pcs_pkg::BkRepToggle: begin
        kind_d = pcs_pkg::KindToggle;
        code_d = rec_q.tog_code;
        last_d = 1'b1;
        if (load) begin
          state_d = pcs_pkg::BkIdle;
        end
      end
      default: ;
    endcase

    if (!load) begin
      kind_d = kind_q;
      code_d = code_q;
      last_d = last_q;
    end else begin
      pump_d = rec_q.pump_on;
    end

    // Pick up the next record as soon as the current one is done.
    if (state_d == pcs_pkg::BkIdle && !q_status_i.empty) begin
      pop_o   = 1'b1;
      rec_d   = head_rec_i;
      state_d = head_rec_i.tog_v ? pcs_pkg::BkToggle : pcs_pkg::BkStatus;
    end

    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q  <= rec_d;
    kind_q <= kind_d;
    code_q <= code_d;
    pump_q <= pump_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcs_pkg::BkIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign code_o      = code_q;
  assign pump_on_o   = pump_q;
  assign last_o      = last_q;

`ifndef ASSERT_OFF
  // No report carries the unused code.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (code_q != 2'd3))
    else $error("report with unused code");
  // A status report is always followed by the toggle report of its tick.
  a_status_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == pcs_pkg::KindStatus) |-> !last_q)
    else $error("status report marked last");
  a_status_then_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_ready_i && kind_q == pcs_pkg::KindStatus) |=>
      (valid_q && kind_q == pcs_pkg::KindToggle && last_q))
    else $error("status report not followed by toggle report");
`endif

endmodule

@@ test/tb_pump_cycle_supervisor.sv @@
// Self-checking testbench of pump_cycle_supervisor: a scoreboard class predicts
// the report items of every accepted tick and checks each report as it leaves.
// Depends on pcs_pkg and the pump_cycle_supervisor RTL.
module tb_pump_cycle_supervisor;
  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;

  // One report item as it is seen on the master side.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } report_t;

  // The scoreboard keeps its own copy of the registers and the supervisor
  // state, works out the reports of each accepted tick and queues them in
  // order. Every report that leaves the block is compared with the oldest one.
  class pump_report_board;
    logic [15:0] min_on;
    logic [31:0] max_idle;
    logic [7:0]  alarm_lim;
    logic [15:0] period;
    logic [9:0]  holdoff;

    logic        pump_st;
    logic [9:0]  hold_cnt;
    logic [31:0] since_on;
    logic [15:0] rep_cnt;
    logic [15:0] alarm_cnt;
    logic [15:0] good_cnt;
    logic [1:0]  status;
    logic [1:0]  toggle;
    bit          idle_flag;

    report_t     pending_reports[$];
    int          errors;

    function new();
      min_on    = MinOnReset;
      max_idle  = MaxIdleReset;
      alarm_lim = AlarmLimReset;
      period    = PeriodReset;
      holdoff   = HoldoffReset;
      pump_st   = 1'b0;
      hold_cnt  = '0;
      since_on  = '0;
      rep_cnt   = '0;
      alarm_cnt = '0;
      good_cnt  = '0;
      status    = StatusNoActivity;
      toggle    = ToggleNone;
      idle_flag = 1'b0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CfgMinOn:        min_on    = val[15:0];
        CfgMaxIdle:      max_idle  = val;
        CfgAlarmLimit:   alarm_lim = val[7:0];
        CfgReportPeriod: period    = val[15:0];
        CfgHoldoff:      holdoff   = val[9:0];
        default: ;
      endcase
    endfunction

    // Advance the supervisor by one tick and queue the reports it causes.
    function void note_tick(logic lvl);
      report_t batch[3];
      int      n;
      n = 0;
      if (since_on != 32'hFFFF_FFFF) since_on++;
      if (rep_cnt != 16'hFFFF) rep_cnt++;

      if (hold_cnt != 0) begin
        hold_cnt--;
      end else if (lvl != pump_st) begin
        pump_st  = lvl;
        hold_cnt = holdoff;
        if (lvl) begin
          toggle   = ToggleOn;
          since_on = '0;
        end else begin
          toggle = ToggleOff;
          if (since_on < {16'b0, min_on}) begin
            if (alarm_cnt != 16'hFFFF) alarm_cnt++;
            if (alarm_cnt >= {8'b0, alarm_lim}) begin
              status   = StatusLowAir;
              good_cnt = '0;
            end
          end else begin
            if (good_cnt != 16'hFFFF) good_cnt++;
            if (good_cnt > alarm_cnt) begin
              status    = StatusOk;
              alarm_cnt = '0;
            end
          end
        end
        batch[n] = '{KindToggle, {5'b0, pump_st, toggle}, 1'b0};
        n++;
      end

      // The idle flag only lets the status fall to no activity once per
      // idle stretch, so a later edge can still move it.
      if (since_on > max_idle) begin
        if (!idle_flag) begin
          status    = StatusNoActivity;
          idle_flag = 1'b1;
        end
      end else begin
        idle_flag = 1'b0;
      end

      if (rep_cnt >= period) begin
        rep_cnt  = '0;
        batch[n] = '{KindStatus, {5'b0, pump_st, status}, 1'b0};
        n++;
        batch[n] = '{KindToggle, {5'b0, pump_st, toggle}, 1'b0};
        n++;
      end

      if (n > 0) batch[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) pending_reports.push_back(batch[i]);
    endfunction

    function void check_report(logic kind, logic [7:0] data, logic last);
      report_t exp_rep;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report kind=%0b data=%02h last=%0b",
                 $time, kind, data, last);
        errors++;
        return;
      end
      exp_rep = pending_reports.pop_front();
      if (kind !== exp_rep.kind) begin
        $display("%0t: report kind expected %0b actual %0b", $time, exp_rep.kind, kind);
        errors++;
      end
      if (data[1:0] !== exp_rep.data[1:0]) begin
        $display("%0t: code expected %0d actual %0d", $time, exp_rep.data[1:0], data[1:0]);
        errors++;
      end
      if (data[2] !== exp_rep.data[2]) begin
        $display("%0t: pump_on expected %0b actual %0b", $time, exp_rep.data[2], data[2]);
        errors++;
      end
      if (data[7:3] !== exp_rep.data[7:3]) begin
        $display("%0t: padding bits expected %02h actual %02h",
                 $time, exp_rep.data[7:3], data[7:3]);
        errors++;
      end
      if (last !== exp_rep.last) begin
        $display("%0t: tlast expected %0b actual %0b", $time, exp_rep.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [0] pump_level, [7:1] zero
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [1:0] code, [2] pump_on, [7:3] zero
  logic                m_axis_tuser;   // [0] report_kind
  logic                m_axis_tlast;

  pump_report_board board;

  // Idling controls shared by the sender, the receiver and the main sequence.
  int send_idle_pct;
  int recv_stall_pct;
  bit long_hold_req;

  pump_cycle_supervisor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a correct run ends long before this point.
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: stalls at random with the current stall rate. On request it
  // holds tready low for a long stretch so that the record queue fills and
  // the block has to stall its input.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: every accepted report is checked against the oldest expectation.
  // Signals are read at the edge, so the values seen are the ones that the
  // flops sample at that edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        board.check_report(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  // Offer one tick, after a random gap, and hold it until it is taken.
  // Called and returning at a rising edge.
  task automatic send_tick(input logic lvl);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-1){1'b0}}, lvl};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_tick(lvl);
  endtask

  // Directed ticks: bit i of the pattern is the level of tick i.
  task automatic send_levels(input logic [31:0] pattern, input int count);
    for (int i = 0; i < count; i++) send_tick(pattern[i]);
    s_axis_tvalid <= 1'b0;
  endtask

  // Random ticks shaped as pump runs: on and off stretches whose lengths
  // straddle the minimum on time, so both alarms and good runs occur, with
  // a little switch bounce mixed in.
  task automatic send_runs(input int count, input int min_on);
    logic lvl;
    int   run_left;
    lvl      = 1'b0;
    run_left = 0;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        lvl      = ~lvl;
        run_left = $urandom_range(2 * min_on + 3, 1);
      end
      run_left--;
      send_tick(lvl ^ ($urandom_range(99) < 15));
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait until every expected report has left, then give silent ticks still
  // inside the block time to pass through.
  task automatic drain();
    while (board.pending_reports.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  // Write all five registers back to back; only called while the block is idle.
  task automatic set_config(input logic [15:0] min_on, input logic [31:0] max_idle,
                            input logic [7:0] alarm_lim, input logic [15:0] period,
                            input logic [9:0] holdoff);
    write_reg(CfgMinOn,        {16'b0, min_on});
    write_reg(CfgMaxIdle,      max_idle);
    write_reg(CfgAlarmLimit,   {24'b0, alarm_lim});
    write_reg(CfgReportPeriod, {16'b0, period});
    write_reg(CfgHoldoff,      {22'b0, holdoff});
    cfg_we_i <= 1'b0;
  endtask

  // Main sequence: reset, directed phases, random phases under the four
  // idling mixes with one long receiver hold-off, a long hold-off phase last.
  initial begin
    int          min_on;
    logic [31:0] max_idle;
    board          = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req  = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register values after reset: level stays off, so no report is due.
    send_levels(32'h0, 2);
    drain();

    // A short run gives an alarm and low air, two longer runs bring status
    // back to OK, then the idle limit gives no activity. Reports every 5 ticks.
    set_config(16'd3, 32'd3, 8'd1, 16'd5, 10'd0);
    send_levels(32'h7BD, 16);
    drain();

    // All registers zero: a status report every tick, every alarm gives
    // low air, and no input is ever ignored.
    set_config(16'd0, 32'd0, 8'd0, 16'd0, 10'd0);
    send_levels(32'hD, 7);
    drain();

    // Upper extremes with a short hold-off that swallows fast toggles.
    set_config(16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 10'd2);
    send_levels(32'h71, 8);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      min_on   = $urandom_range(6, 0);
      max_idle = ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(30, 0);
      if (ph == 4) begin
        // Reports on every tick while the receiver holds off for a long time.
        set_config(min_on[15:0], max_idle, 8'($urandom_range(4, 0)), 16'd1, 10'd0);
        long_hold_req = 1'b1;
      end else begin
        set_config(min_on[15:0], max_idle, 8'($urandom_range(4, 0)),
                   16'($urandom_range(10, 0)), 10'($urandom_range(3, 0)));
      end
      send_runs(36, min_on);
      drain();
    end

    // Longest hold-off: after the first toggle every later change is ignored.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(16'd2, 32'd10, 8'd2, 16'd3, 10'h3FF);
    send_levels(32'h15, 6);
    drain();

    if (board.errors == 0 && board.pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ pump_cycle_supervisor.f @@
sv/pcs_pkg.sv
sv/pcs_front.sv
sv/pcs_queue.sv
sv/pcs_back.sv
sv/pump_cycle_supervisor.sv
test/tb_pump_cycle_supervisor.sv
